// File: rtl/json_token_serializer_top_defines.svh
// ----------------------------------------------------------------------------
// JSON token serializer assertion macros
// Shared property templates, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_SERIALIZER_TOP_DEFINES_SVH
`define JSON_TOKEN_SERIALIZER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/jts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token serializer package
// Item types, token and level codes, character constants and small tables.
// ----------------------------------------------------------------------------
package jts_pkg;

  localparam int unsigned MAX_DEPTH = 32;

  typedef enum logic [2:0] {
    MODE_OBJ_OPEN  = 3'd0,
    MODE_OBJ_CLOSE = 3'd1,
    MODE_ARR_OPEN  = 3'd2,
    MODE_ARR_CLOSE = 3'd3,
    MODE_INT       = 3'd4,
    MODE_BOOL      = 3'd5,
    MODE_NULL      = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    LV_NONE     = 3'd0,
    LV_MAP_OPEN = 3'd1,
    LV_MAP_KEY  = 3'd3,
    LV_MAP_VAL  = 3'd4,
    LV_ARY_OPEN = 3'd5,
    LV_ARY_VAL  = 3'd7
  } level_e;

  typedef enum logic [1:0] {
    LIT_TRUE  = 2'd0,
    LIT_FALSE = 2'd1,
    LIT_NULL  = 2'd2
  } lit_e;

  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_COMMA     = ",";
  localparam logic [7:0] CH_COLON     = ":";
  localparam logic [7:0] CH_MINUS     = "-";
  localparam logic [7:0] CH_OBJ_OPEN  = "{";
  localparam logic [7:0] CH_OBJ_CLOSE = "}";
  localparam logic [7:0] CH_ARR_OPEN  = "[";
  localparam logic [7:0] CH_ARR_CLOSE = "]";

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } dig_ctrl_t;

  function automatic logic [33:0] pow10(input logic [3:0] k);
    logic [33:0] p;
    case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] lit_char(input lit_e sel, input logic [2:0] idx);
    logic [7:0] c;
    c = "e";
    case (sel)
      LIT_TRUE: begin
        case (idx)
          3'd0:    c = "t";
          3'd1:    c = "r";
          3'd2:    c = "u";
          default: c = "e";
        endcase
      end
      LIT_FALSE: begin
        case (idx)
          3'd0:    c = "f";
          3'd1:    c = "a";
          3'd2:    c = "l";
          3'd3:    c = "s";
          default: c = "e";
        endcase
      end
      LIT_NULL: begin
        case (idx)
          3'd0:    c = "n";
          3'd1:    c = "u";
          default: c = "l";
        endcase
      end
      default: c = "e";
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_last_idx(input lit_e sel);
    logic [2:0] n;
    case (sel)
      LIT_FALSE: n = 3'd4;
      default:   n = 3'd3;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/jts_level_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level state memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jts_level_ram #(
  parameter int unsigned DEPTH = jts_pkg::MAX_DEPTH + 1,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [2:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [2:0]    rdata_o
);

  logic [2:0] mem_q [DEPTH];
  logic [2:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/jts_dec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit unit
// Holds an integer magnitude and yields its decimal digits, most significant
// first, one digit per step.
// ----------------------------------------------------------------------------
module jts_dec_unit (
  input  logic               clk_i,
  input  jts_pkg::dig_ctrl_t ctrl_i,
  input  logic signed [31:0] value_i,
  output logic [3:0]         digit_o,
  output logic               pos_zero_o
);

  logic [31:0] mag_q, mag_d;
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  top_pos;
  logic [3:0]  digit;
  logic [33:0] sub;
  logic [33:0] mult;

  always_comb begin
    top_pos = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, mag_q} >= jts_pkg::pow10(4'(k))) begin
        top_pos = top_pos + 4'd1;
      end
    end
  end

  always_comb begin
    digit = 4'd0;
    sub   = 34'd0;
    mult  = 34'd0;
    for (int j = 1; j <= 9; j++) begin
      mult = 34'(j) * jts_pkg::pow10(pos_q);
      if ({2'b00, mag_q} >= mult) begin
        digit = 4'(j);
        sub   = mult;
      end
    end
  end

  always_comb begin
    mag_d = mag_q;
    pos_d = pos_q;
    if (ctrl_i.load) begin
      mag_d = value_i[31] ? (32'd0 - $unsigned(value_i)) : $unsigned(value_i);
    end else if (ctrl_i.init) begin
      pos_d = top_pos;
    end else if (ctrl_i.step) begin
      mag_d = mag_q - sub[31:0];
      pos_d = pos_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    pos_q <= pos_d;
  end

  assign digit_o    = digit;
  assign pos_zero_o = (pos_q == 4'd0);

endmodule

// File: rtl/json_token_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token serializer
// Turns JSON writer tokens into a stream of JSON text bytes.
// ----------------------------------------------------------------------------
// One token is handled at a time. A token is taken in a cycle during which
// the container state of the current depth is read from the level memory; the
// next cycle decides the separator and, but for a closing token or an error,
// writes the updated state back; then the token's bytes leave one per cycle
// through the output register while the output is not stalled. An error item
// yields a single final zero byte with the error flag set, and an unused token
// kind is taken and dropped. The byte rate of the output register sets this
// pace, and a stalled output holds the block.
module json_token_serializer_top #(
  parameter int unsigned MAX_DEPTH = jts_pkg::MAX_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jts_pkg::out_item_t out_item_o
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEP  = 3'b010,
    ST_BODY = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [DW-1:0]      depth_q, depth_d;
  logic [2:0]         mode_q;
  logic               truth_q;
  logic               sign_pend_q, sign_pend_d;
  logic [2:0]         lit_idx_q, lit_idx_d;
  logic               out_valid_q, out_valid_d;
  jts_pkg::out_item_t out_item_q, out_item_d;

  logic               in_fire;
  logic               slot_free;
  logic               emit;
  jts_pkg::out_item_t emit_item;
  logic               ram_we;
  logic [DW-1:0]      ram_waddr;
  logic [2:0]         ram_wdata;
  logic [2:0]         ram_rdata;
  jts_pkg::level_e    cur_level, new_level;
  logic               sep_has_byte;
  logic [7:0]         sep_byte;
  logic               is_open, is_close, tok_err;
  jts_pkg::lit_e      lit_sel;
  jts_pkg::dig_ctrl_t dig_ctrl;
  logic [3:0]         digit;
  logic               pos_zero;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  jts_level_ram #(
    .DEPTH (MAX_DEPTH + 1)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (depth_q),
    .rdata_o (ram_rdata)
  );

  jts_dec_unit u_dec_unit (
    .clk_i      (clk_i),
    .ctrl_i     (dig_ctrl),
    .value_i    (in_item_i.value),
    .digit_o    (digit),
    .pos_zero_o (pos_zero)
  );

  always_comb begin
    is_open  = (mode_q inside {jts_pkg::MODE_OBJ_OPEN, jts_pkg::MODE_ARR_OPEN});
    is_close = (mode_q inside {jts_pkg::MODE_OBJ_CLOSE, jts_pkg::MODE_ARR_CLOSE});
    tok_err  = (is_open && (depth_q == DW'(MAX_DEPTH))) || (is_close && (depth_q == '0));
    lit_sel  = (mode_q == jts_pkg::MODE_NULL) ? jts_pkg::LIT_NULL :
               (truth_q ? jts_pkg::LIT_TRUE : jts_pkg::LIT_FALSE);
  end

  always_comb begin
    cur_level    = (depth_q == '0) ? jts_pkg::LV_NONE : jts_pkg::level_e'(ram_rdata);
    new_level    = cur_level;
    sep_has_byte = 1'b0;
    sep_byte     = jts_pkg::CH_COMMA;
    case (cur_level)
      jts_pkg::LV_MAP_OPEN: new_level = jts_pkg::LV_MAP_KEY;
      jts_pkg::LV_ARY_OPEN: new_level = jts_pkg::LV_ARY_VAL;
      jts_pkg::LV_ARY_VAL: begin
        sep_has_byte = 1'b1;
      end
      jts_pkg::LV_MAP_KEY: begin
        sep_has_byte = 1'b1;
        sep_byte     = jts_pkg::CH_COLON;
        new_level    = jts_pkg::LV_MAP_VAL;
      end
      jts_pkg::LV_MAP_VAL: begin
        sep_has_byte = 1'b1;
        new_level    = jts_pkg::LV_MAP_KEY;
      end
      default: new_level = cur_level;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    sign_pend_d = sign_pend_q;
    lit_idx_d   = lit_idx_q;
    emit        = 1'b0;
    emit_item   = '{out_byte: 8'd0, last: 1'b0, error: 1'b0};
    ram_we      = 1'b0;
    ram_waddr   = depth_q;
    ram_wdata   = new_level;
    dig_ctrl    = '{load: in_fire, init: 1'b0, step: 1'b0};

    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_item_i.mode <= jts_pkg::MODE_NULL)) begin
          state_d = ST_SEP;
        end
      end
      ST_SEP: begin
        dig_ctrl.init = 1'b1;
        if (tok_err) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_item = '{out_byte: 8'd0, last: 1'b1, error: 1'b1};
            state_d   = ST_IDLE;
          end
        end else if (is_close) begin
          state_d = ST_BODY;
        end else if (sep_has_byte) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_item = '{out_byte: sep_byte, last: 1'b0, error: 1'b0};
            ram_we    = 1'b1;
            state_d   = ST_BODY;
          end
        end else begin
          ram_we  = 1'b1;
          state_d = ST_BODY;
        end
      end
      ST_BODY: begin
        if (slot_free) begin
          emit = 1'b1;
          case (mode_q)
            jts_pkg::MODE_OBJ_OPEN, jts_pkg::MODE_ARR_OPEN: begin
              emit_item.out_byte = (mode_q == jts_pkg::MODE_OBJ_OPEN) ?
                                   jts_pkg::CH_OBJ_OPEN : jts_pkg::CH_ARR_OPEN;
              emit_item.last     = 1'b1;
              ram_we             = 1'b1;
              ram_waddr          = depth_q + DW'(1);
              ram_wdata          = (mode_q == jts_pkg::MODE_OBJ_OPEN) ?
                                   jts_pkg::LV_MAP_OPEN : jts_pkg::LV_ARY_OPEN;
              depth_d            = depth_q + DW'(1);
              state_d            = ST_IDLE;
            end
            jts_pkg::MODE_OBJ_CLOSE, jts_pkg::MODE_ARR_CLOSE: begin
              emit_item.out_byte = (mode_q == jts_pkg::MODE_OBJ_CLOSE) ?
                                   jts_pkg::CH_OBJ_CLOSE : jts_pkg::CH_ARR_CLOSE;
              emit_item.last     = 1'b1;
              depth_d            = depth_q - DW'(1);
              state_d            = ST_IDLE;
            end
            jts_pkg::MODE_INT: begin
              if (sign_pend_q) begin
                emit_item.out_byte = jts_pkg::CH_MINUS;
                sign_pend_d        = 1'b0;
              end else begin
                emit_item.out_byte = jts_pkg::CH_ZERO + {4'd0, digit};
                emit_item.last     = pos_zero;
                dig_ctrl.step      = 1'b1;
                if (pos_zero) begin
                  state_d = ST_IDLE;
                end
              end
            end
            jts_pkg::MODE_BOOL, jts_pkg::MODE_NULL: begin
              emit_item.out_byte = jts_pkg::lit_char(lit_sel, lit_idx_q);
              emit_item.last     = (lit_idx_q == jts_pkg::lit_last_idx(lit_sel));
              lit_idx_d          = lit_idx_q + 3'd1;
              if (emit_item.last) begin
                state_d = ST_IDLE;
              end
            end
            default: begin
              emit    = 1'b0;
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = emit || (out_valid_q && !out_ready_i);
    out_item_d  = emit ? emit_item : out_item_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q      <= in_item_i.mode;
      truth_q     <= (in_item_i.value != 32'sd0);
      sign_pend_q <= in_item_i.value[31];
      lit_idx_q   <= 3'd0;
    end else begin
      sign_pend_q <= sign_pend_d;
      lit_idx_q   <= lit_idx_d;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/jts_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token serializer checker
// Port-level properties of the serializer, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_token_serializer_top_defines.svh"

module jts_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input jts_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input jts_pkg::out_item_t out_item_o
);

  `JTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "Output item changed or dropped while stalled.")

  `JTS_ASSERT_IMPL(a_err_form, out_valid_o && out_item_o.error, out_item_o.last && (out_item_o.out_byte == 8'd0), "Error item is not a single final zero byte.")

  `JTS_ASSERT_IMPL(a_text_nonzero, out_valid_o && (out_item_o.out_byte == 8'd0), out_item_o.error, "Zero byte shown without the error flag.")

  `JTS_ASSERT_NEXT(a_one_token, in_valid_i && in_ready_o && (in_item_i.mode <= jts_pkg::MODE_NULL), !in_ready_o, "A new item was taken while a token was still in work.")

endmodule

bind json_token_serializer_top jts_chk u_jts_chk (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token serializer testbench
// Sends JSON writer tokens through the valid/ready input and checks every
// output byte against a local model of the separator stack and number
// formatting. The stimulus has a short directed opening, then mostly nested
// documents with random content, plus dives to the maximum depth, random
// noise tokens, random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import jts_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int unsigned TOKEN_TARGET = 350;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned CYCLE_LIMIT = 600000;

  class json_text_checker;
    int unsigned depth;
    int unsigned deepest;
    level_e level_st [0:MAX_DEPTH];
    logic [7:0] text[$];
    out_item_t expected_text[$];
    int unsigned error_items;
    int unsigned bytes_checked;
    int unsigned mismatches;

    function new();
      depth = 0;
      deepest = 0;
      foreach (level_st[i]) level_st[i] = LV_NONE;
      error_items = 0;
      bytes_checked = 0;
      mismatches = 0;
    endfunction

    function void put_separator();
      case (level_st[depth])
        LV_MAP_OPEN: level_st[depth] = LV_MAP_KEY;
        LV_ARY_OPEN: level_st[depth] = LV_ARY_VAL;
        LV_ARY_VAL:  text.push_back(CH_COMMA);
        LV_MAP_KEY: begin
          text.push_back(CH_COLON);
          level_st[depth] = LV_MAP_VAL;
        end
        LV_MAP_VAL: begin
          text.push_back(CH_COMMA);
          level_st[depth] = LV_MAP_KEY;
        end
        default: ;
      endcase
    endfunction

    function void put_word(string w);
      for (int i = 0; i < w.len(); i++) text.push_back(w[i]);
    endfunction

    function void put_error();
      expected_text.push_back('{out_byte: 8'd0, last: 1'b1, error: 1'b1});
      error_items++;
    endfunction

    function void note_token(in_item_t tok);
      logic [31:0] mag;
      logic [7:0] digs[$];
      text.delete();
      case (tok.mode)
        MODE_OBJ_OPEN, MODE_ARR_OPEN: begin
          if (depth >= MAX_DEPTH) begin
            put_error();
          end else begin
            put_separator();
            depth++;
            if (depth > deepest) deepest = depth;
            level_st[depth] = (tok.mode == MODE_OBJ_OPEN) ? LV_MAP_OPEN : LV_ARY_OPEN;
            text.push_back((tok.mode == MODE_OBJ_OPEN) ? CH_OBJ_OPEN : CH_ARR_OPEN);
          end
        end
        MODE_OBJ_CLOSE, MODE_ARR_CLOSE: begin
          if (depth == 0) begin
            put_error();
          end else begin
            depth--;
            text.push_back((tok.mode == MODE_OBJ_CLOSE) ? CH_OBJ_CLOSE : CH_ARR_CLOSE);
          end
        end
        MODE_INT: begin
          put_separator();
          mag = tok.value[31] ? (32'd0 - tok.value) : tok.value;
          if (tok.value[31]) text.push_back(CH_MINUS);
          do begin
            digs.push_front(CH_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
          end while (mag != 0);
          foreach (digs[i]) text.push_back(digs[i]);
        end
        MODE_BOOL: begin
          put_separator();
          if (tok.value != 0) put_word("true");
          else put_word("false");
        end
        MODE_NULL: begin
          put_separator();
          put_word("null");
        end
        default: ;
      endcase
      foreach (text[i])
        expected_text.push_back('{out_byte: text[i], last: (i == text.size() - 1),
                                  error: 1'b0});
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      bytes_checked++;
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output: byte %02h last %0b error %0b",
                   got.out_byte, got.last, got.error);
      end else begin
        want = expected_text.pop_front();
        if (got.out_byte !== want.out_byte || got.last !== want.last ||
            got.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected byte %02h last %0b error %0b, ",
                      "got byte %02h last %0b error %0b"},
                     want.out_byte, want.last, want.error,
                     got.out_byte, got.last, got.error);
        end
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  json_text_checker sb;
  int unsigned tokens_sent;
  int unsigned ignored_sent;
  int unsigned cycles;
  bit          sender_burst;
  bit          hold_output;

  json_token_serializer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_byte(out_item_o);
  end

  // Output side: a random stall before each byte, bursts without stalls, and
  // one long stall on request.
  initial begin
    int unsigned stall;
    bit fast_drain;
    fast_drain = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = 0;
      if (hold_output) begin
        stall = HOLD_CYCLES;
        hold_output = 1'b0;
      end else if (!fast_drain) begin
        stall = $urandom_range(0, 18);
      end
      if ($urandom_range(0, 29) == 0) fast_drain = !fast_drain;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  task automatic send_token(input logic [2:0] mode, input logic [31:0] value);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 24) == 0) sender_burst = !sender_burst;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i <= '{mode: mode, value: value};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_token(in_item_i);
    if (mode == MODE_UNUSED) ignored_sent++;
    else tokens_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'($urandom_range(0, 19)) - 32'd10;
      3:       v = $urandom >> $urandom_range(0, 31);
      4:       v = 32'd0 - ($urandom >> $urandom_range(1, 31));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_value();
    case ($urandom_range(0, 3))
      0, 1:    send_token(MODE_INT, pick_value());
      2:       send_token(MODE_BOOL, $urandom_range(0, 1) ? 32'd0 : pick_value());
      default: send_token(MODE_NULL, $urandom);
    endcase
  endtask

  task automatic send_open();
    send_token($urandom_range(0, 1) ? MODE_OBJ_OPEN : MODE_ARR_OPEN, $urandom);
  endtask

  task automatic send_close();
    level_e lv;
    lv = sb.level_st[sb.depth];
    if (lv == LV_MAP_OPEN || lv == LV_MAP_KEY || lv == LV_MAP_VAL)
      send_token(MODE_OBJ_CLOSE, $urandom);
    else
      send_token(MODE_ARR_CLOSE, $urandom);
  endtask

  task automatic send_wellformed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.depth == 0) begin
      if (r < 80) send_open();
      else send_value();
    end else if (r < 10 + 4 * sb.depth) begin
      send_close();
    end else if (r < 30 + 4 * sb.depth) begin
      send_open();
    end else begin
      send_value();
    end
  endtask

  task automatic dive_to_limit();
    while (sb.depth < MAX_DEPTH) begin
      send_open();
      if ($urandom_range(0, 2) == 0) send_value();
    end
    repeat (2) send_open();
    send_value();
    while (sb.depth > 0) begin
      send_close();
      if ($urandom_range(0, 2) == 0) send_value();
    end
    send_close();
  endtask

  initial begin
    sb = new();
    tokens_sent = 0;
    ignored_sent = 0;
    cycles = 0;
    sender_burst = 1'b0;
    hold_output = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_token(MODE_OBJ_CLOSE, 32'd0);
    send_token(MODE_ARR_CLOSE, 32'hFFFF_FFFF);
    send_token(MODE_INT, 32'h8000_0000);
    send_token(MODE_INT, 32'h7FFF_FFFF);
    send_token(MODE_INT, 32'd0);
    send_token(MODE_INT, 32'hFFFF_FFFF);
    send_token(MODE_BOOL, 32'd1);
    send_token(MODE_BOOL, 32'h8000_0000);
    send_token(MODE_BOOL, 32'd0);
    send_token(MODE_NULL, 32'd0);
    send_token(MODE_UNUSED, 32'h1234_5678);
    send_token(MODE_OBJ_OPEN, 32'd0);
    send_token(MODE_INT, 32'd1000000000);
    send_token(MODE_INT, 32'd9);
    send_token(MODE_NULL, 32'd0);
    send_token(MODE_ARR_OPEN, 32'd0);
    send_token(MODE_BOOL, 32'd7);
    send_token(MODE_BOOL, 32'd0);
    send_token(MODE_INT, 32'hFFFF_FFF6);
    send_token(MODE_OBJ_CLOSE, 32'd0);
    send_token(MODE_ARR_CLOSE, 32'd0);
    send_token(MODE_OBJ_CLOSE, 32'd0);

    // The long output stall overlaps a burst of deep nesting.
    sender_burst = 1'b1;
    hold_output = 1'b1;
    dive_to_limit();

    while (tokens_sent < TOKEN_TARGET) begin
      case ($urandom_range(0, 99))
        0, 1:                   dive_to_limit();
        2, 3, 4, 5, 6, 7, 8, 9,
        10, 11, 12:             send_token(3'($urandom_range(0, 7)), pick_value());
        default:                send_wellformed();
      endcase
    end
    in_valid_i <= 1'b0;

    while (sb.expected_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display({"Sent %0d tokens and %0d unused-kind items, ",
              "nesting up to depth %0d, %0d error items."},
             tokens_sent, ignored_sent, sb.deepest, sb.error_items);
    $display("Checked %0d output bytes under random idling and one long output stall.",
             sb.bytes_checked);
    if (sb.mismatches == 0 && sb.expected_text.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d bytes still expected", sb.mismatches,
               sb.expected_text.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
